// ===== design/hnorm_pkg.sv =====
// Shared types and constants for the heightmap normal generator.
package hnorm_pkg;

   // Map size limits and derived widths
   localparam int MAX_DIM = 4096;
   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int POS_W   = $clog2(MAX_DIM);

   // Field widths
   localparam int HGT_W   = 8;
   localparam int SLOPE_W = HGT_W + 1;
   localparam int NRM_W   = 16;
   localparam int NZ_W    = 15;

   // Configuration port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = CSR_IDX_W'(1);
   localparam int MAP_RESET = 512;

   // Slope queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QA_W        = $clog2(QUEUE_DEPTH);
   localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

   // Integer height differences (twice the real slope away from the map edges)
   typedef struct packed {
      logic signed [SLOPE_W-1:0] dx;
      logic signed [SLOPE_W-1:0] dy;
   } slope_type;

   // Queue occupancy flags
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== design/heightmap_normal_generator.sv =====
// Heightmap normal generator top level: front end, slope queue and root-search back end.
//
// Takes one grid-point transaction per clock and returns one unit normal per
// clock while neither req_stall nor rsp_stall holds the flow, in order, as Q1.15
// (magnitudes rounded to nearest, saturated to 32767). A normal appears on
// rsp_valid after its transaction passes the front register that forms the
// edge-aware height differences, the four-entry slope queue, and the back end,
// where an entry stage feeds a fifteen-stage search that settles one result bit
// per stage for each component. When rsp_stall holds the result, the queue keeps
// filling and req_stall rises only once it is full. Map sizes written through
// csr_data above 4096 are clamped to 4096; write them only while idle.
module heightmap_normal_generator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [hnorm_pkg::POS_W-1:0]         req_col,
   input  logic [hnorm_pkg::POS_W-1:0]         req_row,
   input  logic [hnorm_pkg::HGT_W-1:0]         req_center_height,
   input  logic [hnorm_pkg::HGT_W-1:0]         req_left_height,
   input  logic [hnorm_pkg::HGT_W-1:0]         req_right_height,
   input  logic [hnorm_pkg::HGT_W-1:0]         req_prev_row_height,
   input  logic [hnorm_pkg::HGT_W-1:0]         req_next_row_height,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [hnorm_pkg::NRM_W-1:0]  rsp_normal_x,
   output logic signed [hnorm_pkg::NRM_W-1:0]  rsp_normal_y,
   output logic [hnorm_pkg::NZ_W-1:0]          rsp_normal_z,
   input  logic                                csr_write,
   input  logic [hnorm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hnorm_pkg::DIM_W-1:0]         csr_data
);
   import hnorm_pkg::*;

   logic         push;
   logic         pop;
   slope_type    push_data;
   slope_type    head;
   q_status_type q_stat;

   // Classify and register incoming transactions
   hnorm_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_col             (req_col),
      .req_row             (req_row),
      .req_center_height   (req_center_height),
      .req_left_height     (req_left_height),
      .req_right_height    (req_right_height),
      .req_prev_row_height (req_prev_row_height),
      .req_next_row_height (req_next_row_height),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .push                (push),
      .push_data           (push_data),
      .q_stat              (q_stat)
   );

   // Buffer slopes between the two sides
   hnorm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   // Compute and deliver the normals
   hnorm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .q_stat       (q_stat),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_normal_x (rsp_normal_x),
      .rsp_normal_y (rsp_normal_y),
      .rsp_normal_z (rsp_normal_z)
   );

endmodule

// ===== design/hnorm_front.sv =====
// Front end: configuration registers, input register and edge classification.
module hnorm_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [hnorm_pkg::POS_W-1:0]         req_col,
   input  logic [hnorm_pkg::POS_W-1:0]         req_row,
   input  logic [hnorm_pkg::HGT_W-1:0]         req_center_height,
   input  logic [hnorm_pkg::HGT_W-1:0]         req_left_height,
   input  logic [hnorm_pkg::HGT_W-1:0]         req_right_height,
   input  logic [hnorm_pkg::HGT_W-1:0]         req_prev_row_height,
   input  logic [hnorm_pkg::HGT_W-1:0]         req_next_row_height,
   input  logic                                csr_write,
   input  logic [hnorm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hnorm_pkg::DIM_W-1:0]         csr_data,
   output logic                                push,
   output hnorm_pkg::slope_type                push_data,
   input  hnorm_pkg::q_status_type             q_stat
);
   import hnorm_pkg::*;

   logic [DIM_W-1:0] map_width_ff, map_width_in;
   logic [DIM_W-1:0] map_height_ff, map_height_in;
   logic [DIM_W-1:0] csr_sat;
   logic             vld_ff, vld_in;
   slope_type        slope_ff, slope_in;
   logic             load;

   // Pick the difference for one axis from the position on the map
   function automatic logic signed [SLOPE_W-1:0] axis_diff(
      input logic [POS_W-1:0] pos,
      input logic [DIM_W-1:0] size,
      input logic [HGT_W-1:0] c,
      input logic [HGT_W-1:0] lo,
      input logic [HGT_W-1:0] hi
   );
      logic [DIM_W-1:0] last;
      logic [SLOPE_W-1:0] a, b;
      begin
         last = size - DIM_W'(1);
         if (pos == '0) begin
            a = {1'b0, hi};
            b = {1'b0, c};
         end else if ({1'b0, pos} == last) begin
            a = {1'b0, c};
            b = {1'b0, lo};
         end else begin
            a = {1'b0, hi};
            b = {1'b0, lo};
         end
         axis_diff = $signed(a - b);
      end
   endfunction

   // Clamp written sizes to the largest map
   always_comb begin
      csr_sat = (csr_data > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : csr_data;
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MAP_WIDTH:  map_width_in  = csr_sat;
            CSR_MAP_HEIGHT: map_height_in = csr_sat;
            default: ;
         endcase
      end
   end

   // Take a new transaction whenever the held one can move into the queue
   assign load      = !vld_ff || !q_stat.full;
   assign req_stall = !load;
   assign push      = vld_ff && !q_stat.full;
   assign push_data = slope_ff;

   always_comb begin
      vld_in   = load ? req_valid : vld_ff;
      slope_in = slope_ff;
      if (load && req_valid) begin
         slope_in.dx = axis_diff(req_col, map_width_ff, req_center_height,
                                 req_left_height, req_right_height);
         slope_in.dy = axis_diff(req_row, map_height_ff, req_center_height,
                                 req_prev_row_height, req_next_row_height);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= DIM_W'(MAP_RESET);
         map_height_ff <= DIM_W'(MAP_RESET);
         vld_ff        <= 1'b0;
      end else begin
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
         vld_ff        <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      slope_ff <= slope_in;
   end

endmodule

// ===== design/hnorm_queue.sv =====
// Short slope queue that decouples the front end from the root search.
module hnorm_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  hnorm_pkg::slope_type     push_data,
   input  logic                     pop,
   output hnorm_pkg::slope_type     head,
   output hnorm_pkg::q_status_type  q_stat
);
   import hnorm_pkg::*;

   slope_type       mem_ff [QUEUE_DEPTH];
   logic [QA_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QA_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign q_stat.full  = (count_ff == QC_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign head         = mem_ff[rd_ptr_ff];

   assign do_push = push && !q_stat.full;
   assign do_pop  = pop && !q_stat.empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QA_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QA_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QC_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/hnorm_back.sv =====
// Back end: squared length and a pipelined bit-by-bit search for each normal component.
module hnorm_back (
   input  logic                                clock,
   input  logic                                reset,
   input  hnorm_pkg::slope_type                head,
   input  hnorm_pkg::q_status_type             q_stat,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [hnorm_pkg::NRM_W-1:0]  rsp_normal_x,
   output logic signed [hnorm_pkg::NRM_W-1:0]  rsp_normal_y,
   output logic [hnorm_pkg::NZ_W-1:0]          rsp_normal_z
);
   import hnorm_pkg::*;

   localparam int SQ_W   = 2 * HGT_W;
   localparam int S_W    = SQ_W + 1;
   localparam int P_W    = SQ_W + 33;
   localparam int Q_W    = S_W + NRM_W + 2;
   localparam int C_W    = P_W + 3;
   localparam int NSTAGE = NZ_W + 1;

   // One component: result bits so far, (2r-1)^2*s and (2r-1)*s
   typedef struct packed {
      logic [NZ_W-1:0]     r;
      logic [P_W-1:0]      p;
      logic signed [Q_W-1:0] q;
   } lane_type;

   typedef struct packed {
      logic [S_W-1:0]  s;
      logic [SQ_W-1:0] sq_x;
      logic [SQ_W-1:0] sq_y;
      logic            neg_x;
      logic            neg_y;
      lane_type        lx;
      lane_type        ly;
      lane_type        lz;
   } stage_type;

   stage_type            stage_ff [NSTAGE];
   stage_type            stage_in [NSTAGE];
   logic [NSTAGE-1:0]    vld_ff, vld_in;
   logic                 adv;
   logic [SLOPE_W-1:0]   abs_x9, abs_y9;
   logic [HGT_W-1:0]     abs_x, abs_y;
   logic [SQ_W-1:0]      sq_x, sq_y;
   logic [S_W-1:0]       s0;
   lane_type             lane0;
   logic [NRM_W-1:0]     rx, ry;

   // Try setting bit k: accept while (2r-1)^2 * s stays within sq * 2^32
   function automatic lane_type search_step(
      input lane_type        ln,
      input logic [S_W-1:0]  s,
      input logic [SQ_W-1:0] sq,
      input int              k
   );
      logic signed [C_W-1:0] qs, ss, cand, lim;
      lane_type              res;
      begin
         qs   = C_W'($signed(ln.q));
         qs   = qs <<< (k + 2);
         ss   = $signed({{(C_W-S_W){1'b0}}, s}) <<< (2 * k + 2);
         cand = $signed({3'd0, ln.p}) + qs + ss;
         lim  = $signed({{(C_W-SQ_W-32){1'b0}}, sq, 32'd0});
         res  = ln;
         if (cand <= lim) begin
            res.p = cand[P_W-1:0];
            res.q = ln.q + $signed({{(Q_W-S_W){1'b0}}, s} << (k + 1));
            res.r = ln.r | (NZ_W'(1) << k);
         end
         search_step = res;
      end
   endfunction

   // Move the whole pipeline unless the finished transaction is held
   assign adv = !(vld_ff[NSTAGE-1] && rsp_stall);
   assign pop = adv && !q_stat.empty;

   // Entry stage: squares, squared length and search start at r = 0
   always_comb begin
      abs_x9 = head.dx[SLOPE_W-1] ? SLOPE_W'(-head.dx) : SLOPE_W'(head.dx);
      abs_y9 = head.dy[SLOPE_W-1] ? SLOPE_W'(-head.dy) : SLOPE_W'(head.dy);
      abs_x  = abs_x9[HGT_W-1:0];
      abs_y  = abs_y9[HGT_W-1:0];
      sq_x   = SQ_W'(abs_x) * SQ_W'(abs_x);
      sq_y   = SQ_W'(abs_y) * SQ_W'(abs_y);
      s0     = S_W'(sq_x) + S_W'(sq_y) + S_W'(4);
      lane0.r = '0;
      lane0.p = P_W'(s0);
      lane0.q = -$signed({{(Q_W-S_W){1'b0}}, s0});
      stage_in[0].s     = s0;
      stage_in[0].sq_x  = sq_x;
      stage_in[0].sq_y  = sq_y;
      stage_in[0].neg_x = !head.dx[SLOPE_W-1] && (head.dx != '0);
      stage_in[0].neg_y = !head.dy[SLOPE_W-1] && (head.dy != '0);
      stage_in[0].lx    = lane0;
      stage_in[0].ly    = lane0;
      stage_in[0].lz    = lane0;

      // Search stages, most significant result bit first
      for (int j = 1; j < NSTAGE; j++) begin
         stage_in[j]    = stage_ff[j-1];
         stage_in[j].lx = search_step(stage_ff[j-1].lx, stage_ff[j-1].s,
                                      stage_ff[j-1].sq_x, NSTAGE - 1 - j);
         stage_in[j].ly = search_step(stage_ff[j-1].ly, stage_ff[j-1].s,
                                      stage_ff[j-1].sq_y, NSTAGE - 1 - j);
         stage_in[j].lz = search_step(stage_ff[j-1].lz, stage_ff[j-1].s,
                                      SQ_W'(4), NSTAGE - 1 - j);
      end
   end

   assign vld_in = {vld_ff[NSTAGE-2:0], pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

   // Apply signs to the finished magnitudes
   assign rx = {1'b0, stage_ff[NSTAGE-1].lx.r};
   assign ry = {1'b0, stage_ff[NSTAGE-1].ly.r};
   assign rsp_valid    = vld_ff[NSTAGE-1];
   assign rsp_normal_x = $signed(stage_ff[NSTAGE-1].neg_x ? NRM_W'(0) - rx : rx);
   assign rsp_normal_y = $signed(stage_ff[NSTAGE-1].neg_y ? NRM_W'(0) - ry : ry);
   assign rsp_normal_z = stage_ff[NSTAGE-1].lz.r;

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the heightmap normal generator: directed and random grid points.
module testbench;
   import hnorm_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 24;
   localparam int RANDOM_PHASES = 9;
   localparam int PHASE_POINTS  = 200;

   // Register indexes the block does not decode
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = CSR_IDX_W'(3);

   typedef struct {
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic [HGT_W-1:0] center;
      logic [HGT_W-1:0] left;
      logic [HGT_W-1:0] right;
      logic [HGT_W-1:0] prev_row;
      logic [HGT_W-1:0] next_row;
   } grid_point_type;

   typedef struct {
      logic signed [NRM_W-1:0] x;
      logic signed [NRM_W-1:0] y;
      logic [NZ_W-1:0]         z;
   } normal_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [POS_W-1:0]           req_col = '0;
   logic [POS_W-1:0]           req_row = '0;
   logic [HGT_W-1:0]           req_center_height = '0;
   logic [HGT_W-1:0]           req_left_height = '0;
   logic [HGT_W-1:0]           req_right_height = '0;
   logic [HGT_W-1:0]           req_prev_row_height = '0;
   logic [HGT_W-1:0]           req_next_row_height = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [NRM_W-1:0]    rsp_normal_x;
   logic signed [NRM_W-1:0]    rsp_normal_y;
   logic [NZ_W-1:0]            rsp_normal_z;
   logic                       csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [DIM_W-1:0]           csr_data = '0;

   // Local copy of the map size registers
   logic [DIM_W-1:0] width_model = DIM_W'(MAP_RESET);
   logic [DIM_W-1:0] height_model = DIM_W'(MAP_RESET);

   normal_type normals_due[$];
   normal_type due;
   bit      calm = 1'b0;
   int      stall_left = 0;
   int      points_sent = 0;
   int      normals_checked = 0;
   int      size_writes = 0;
   int      mismatches = 0;
   int      cycles = 0;

   heightmap_normal_generator uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_col             (req_col),
      .req_row             (req_row),
      .req_center_height   (req_center_height),
      .req_left_height     (req_left_height),
      .req_right_height    (req_right_height),
      .req_prev_row_height (req_prev_row_height),
      .req_next_row_height (req_next_row_height),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_normal_x        (rsp_normal_x),
      .rsp_normal_y        (rsp_normal_y),
      .rsp_normal_z        (rsp_normal_z),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Edge-aware height difference along one axis (twice the real slope away from the edges)
   function automatic int axis_slope(logic [POS_W-1:0] pos, logic [DIM_W-1:0] size,
                                     logic [HGT_W-1:0] mid_h, logic [HGT_W-1:0] lo_h,
                                     logic [HGT_W-1:0] hi_h);
      logic [DIM_W-1:0] last_pos;
      last_pos = size - DIM_W'(1);
      if (pos == '0)
         return int'(hi_h) - int'(mid_h);
      if ({1'b0, pos} == last_pos)
         return int'(mid_h) - int'(lo_h);
      return int'(hi_h) - int'(lo_h);
   endfunction

   // Largest r with (2r-1)^2 * sum <= mag^2 * 2^32, i.e. round(mag*32768/sqrt(sum)), saturated
   function automatic int unsigned round_component(int unsigned mag, longint unsigned sum);
      longint unsigned target;
      longint unsigned odd;
      int unsigned     lo;
      int unsigned     hi;
      int unsigned     mid;
      target = 64'(mag * mag) << 32;
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         odd = 64'(mid) * 2 - 1;
         if (odd * odd * sum <= target)
            lo = mid;
         else
            hi = mid - 1;
      end
      return (lo > 32767) ? 32767 : lo;
   endfunction

   function automatic logic [NRM_W-1:0] signed_q15(int comp, longint unsigned sum);
      int unsigned r;
      r = round_component((comp < 0) ? -comp : comp, sum);
      return (comp < 0) ? NRM_W'(0 - r) : NRM_W'(r);
   endfunction

   function automatic normal_type predict_normal(grid_point_type p);
      normal_type      n;
      int              dx;
      int              dy;
      longint unsigned sum;
      dx = axis_slope(p.col, width_model, p.center, p.left, p.right);
      dy = axis_slope(p.row, height_model, p.center, p.prev_row, p.next_row);
      sum = 64'(dx * dx + dy * dy + 4);
      n.x = signed_q15(-dx, sum);
      n.y = signed_q15(-dy, sum);
      n.z = NZ_W'(round_component(2, sum));
      return n;
   endfunction

   function automatic grid_point_type make_point(int col, int row, int c, int l, int r,
                                                 int u, int d);
      grid_point_type p;
      p.col = POS_W'(col);
      p.row = POS_W'(row);
      p.center = HGT_W'(c);
      p.left = HGT_W'(l);
      p.right = HGT_W'(r);
      p.prev_row = HGT_W'(u);
      p.next_row = HGT_W'(d);
      return p;
   endfunction

   // Favor the edges of the map, with some positions past it
   function automatic logic [POS_W-1:0] pick_pos(logic [DIM_W-1:0] size);
      logic [DIM_W-1:0] last_pos;
      last_pos = size - DIM_W'(1);
      case ($urandom_range(0, 9))
         0, 1: return '0;
         2, 3: return POS_W'(last_pos);
         4: return POS_W'($urandom);
         default: return (size < 2) ? POS_W'($urandom) : POS_W'($urandom_range(0, size - 1));
      endcase
   endfunction

   function automatic logic [HGT_W-1:0] pick_height();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return HGT_W'($urandom);
      endcase
   endfunction

   // Send one grid point transaction and record its expected normal
   task automatic send_point(grid_point_type p);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_col <= p.col;
      req_row <= p.row;
      req_center_height <= p.center;
      req_left_height <= p.left;
      req_right_height <= p.right;
      req_prev_row_height <= p.prev_row;
      req_next_row_height <= p.next_row;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      normals_due.push_back(predict_normal(p));
      points_sent++;
   endtask

   // Drop valid and let the pipeline drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (normals_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [DIM_W-1:0] value);
      logic [DIM_W-1:0] kept;
      kept = (value > MAX_DIM) ? DIM_W'(MAX_DIM) : value;
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (index == CSR_MAP_WIDTH)
         width_model = kept;
      else if (index == CSR_MAP_HEIGHT)
         height_model = kept;
      size_writes++;
   endtask

   task automatic check_field(string name, int expected, int actual);
      if (expected != actual) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, expected, actual);
         mismatches++;
      end
   endtask

   // Map edges and points past the edge under the reset map size
   task automatic test_reset_sizes();
      send_point(make_point(0, 0, 100, 100, 100, 100, 100));
      send_point(make_point(511, 511, 200, 0, 9, 0, 9));
      send_point(make_point(512, 4095, 7, 30, 250, 250, 30));
      send_point(make_point(1, 510, 50, 49, 51, 60, 40));
   endtask

   // Steepest slopes in both directions, and the first/last rules
   task automatic test_slope_extremes();
      send_point(make_point(5, 5, 0, 0, 255, 0, 0));
      send_point(make_point(5, 5, 0, 255, 0, 0, 0));
      send_point(make_point(5, 5, 0, 0, 0, 0, 255));
      send_point(make_point(5, 5, 0, 0, 0, 255, 0));
      send_point(make_point(5, 5, 128, 0, 255, 0, 255));
      send_point(make_point(5, 5, 128, 255, 0, 255, 0));
      send_point(make_point(0, 5, 0, 255, 255, 0, 0));
      send_point(make_point(511, 5, 0, 255, 255, 0, 0));
      send_point(make_point(5, 0, 255, 0, 0, 255, 0));
      send_point(make_point(5, 511, 255, 0, 0, 0, 255));
      send_point(make_point(5, 5, 255, 255, 255, 255, 255));
   endtask

   // Degenerate, oversized and undecoded register writes
   task automatic test_register_corners();
      wait_idle();
      write_register(CSR_MAP_WIDTH, DIM_W'(0));
      write_register(CSR_MAP_HEIGHT, DIM_W'(1));
      send_point(make_point(0, 0, 10, 90, 200, 90, 30));
      send_point(make_point(4095, 1, 10, 90, 200, 90, 30));
      wait_idle();
      write_register(CSR_MAP_WIDTH, '1);
      write_register(CSR_MAP_HEIGHT, DIM_W'(MAX_DIM + 1));
      send_point(make_point(4095, 4095, 255, 0, 9, 0, 9));
      wait_idle();
      write_register(CSR_SPARE_2, '1);
      write_register(CSR_SPARE_3, '0);
      send_point(make_point(4095, 4094, 0, 255, 9, 3, 200));
      wait_idle();
      write_register(CSR_MAP_WIDTH, DIM_W'(2));
      write_register(CSR_MAP_HEIGHT, DIM_W'(2));
      send_point(make_point(0, 1, 40, 255, 80, 0, 255));
      send_point(make_point(1, 0, 40, 0, 80, 255, 10));
   endtask

   function automatic logic [DIM_W-1:0] pick_size();
      case ($urandom_range(0, 9))
         0: return DIM_W'(2);
         1: return DIM_W'(MAX_DIM);
         2: return DIM_W'($urandom_range(MAX_DIM + 1, 8191));
         3: return DIM_W'($urandom_range(0, 1));
         4, 5: return DIM_W'($urandom_range(2, MAX_DIM));
         default: return DIM_W'($urandom_range(2, 64));
      endcase
   endfunction

   // Random grid points over several map sizes
   task automatic test_random_maps();
      grid_point_type p;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         write_register(CSR_MAP_WIDTH, pick_size());
         write_register(CSR_MAP_HEIGHT, pick_size());
         if (phase % 3 == 2)
            write_register($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3, DIM_W'($urandom));
         for (int n = 0; n < PHASE_POINTS; n++) begin
            if (n % 50 == 0)
               calm = ($urandom_range(0, 3) == 0);
            p.col = pick_pos(width_model);
            p.row = pick_pos(height_model);
            p.center = pick_height();
            p.left = pick_height();
            p.right = pick_height();
            p.prev_row = pick_height();
            p.next_row = pick_height();
            send_point(p);
         end
      end
      calm = 1'b0;
   endtask

   // Check each accepted normal and draw the hold for the next one
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (normals_due.size() == 0) begin
            $display("%0t: unexpected normal, expected none, got (%0d, %0d, %0d)", $time,
                     rsp_normal_x, rsp_normal_y, rsp_normal_z);
            mismatches++;
         end else begin
            due = normals_due.pop_front();
            check_field("normal_x", due.x, rsp_normal_x);
            check_field("normal_y", due.y, rsp_normal_y);
            check_field("normal_z", due.z, rsp_normal_z);
            normals_checked++;
         end
         stall_left = calm ? 0 : $urandom_range(0, 10);
      end else if (stall_left > 0) begin
         stall_left--;
      end
      rsp_stall <= (stall_left > 0);
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_sizes();
      test_slope_extremes();
      test_register_corners();
      test_random_maps();
      wait_idle();
      $display("summary: %0d grid points sent, %0d normals checked, %0d register writes",
               points_sent, normals_checked, size_writes);
      $display("summary: map edges, steepest slopes, degenerate and clamped sizes covered");
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
